@@ design/nnc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nnc_pkg
// Shared types, constants and helper functions for the nearest-neighbor
// concentration pull core.
// ----------------------------------------------------------------------------
package nnc_pkg;

    // Number of species the model is built for.
    localparam int SPECIES_DEF = 2;

    // Configuration register map.
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] ADDR_EQ_DIST = 3'h0;
    localparam logic [CFG_ADDR_W-1:0] ADDR_TIME_STEP = 3'h4;
    localparam logic [31:0] EQ_DIST_RESET = 32'h0001_0000;
    localparam logic [31:0] TIME_STEP_RESET = 32'h0001_0000;

    // Squared radius of the reset radius (1.0 squared in Q32.32).
    localparam logic [63:0] BEST_RESET = 64'h0000_0001_0000_0000;

    // Item kinds carried in the input tuser.
    localparam logic OP_AGENT = 1'b0;
    localparam logic OP_NEIGHBOR = 1'b1;

    // Iteration counts of the shared root and divide steps.
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS = 17;
    localparam int CNT_W = 5;

    // Operand choice for the shared multiplier.
    typedef enum logic [2:0] {
        MS_DX,
        MS_DY,
        MS_DZ,
        MS_DD,
        MS_FRAC,
        MS_DT
    } mul_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     take;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_load;
        logic     acc_add;
        logic     cmp;
        logic     arm_set;
        logic     clr_flags;
        logic     sqrt_init;
        logic     sqrt_step;
        logic     div_init;
        logic     div_step;
        logic     frac_zero;
        logic     ln_diff;
        logic     ln_upd;
        logic     lane;
        logic     emit;
    } nnc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_op;
        logic item_last;
        logic found;
        logic d_nonzero;
        logic root_lt_d;
        logic out_busy;
    } nnc_stat_t;

    // 64-bit add that sticks at all ones on overflow.
    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add64 = s[64] ? {64{1'b1}} : s[63:0];
        end
    endfunction

    // Magnitude of the difference of two signed 32-bit values.
    function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        logic [32:0] n;
        begin
            d = {a[31], a} - {b[31], b};
            n = -d;
            abs_diff = d[32] ? n[31:0] : d[31:0];
        end
    endfunction

endpackage
`default_nettype wire

@@ design/nnc_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nnc_datapath
// Agent state, nearest-neighbor search registers, shared multiplier,
// bit-serial square root and divider, and the output register.
// ----------------------------------------------------------------------------
module nnc_datapath
    import nnc_pkg::*;
#(
    parameter int SPECIES = SPECIES_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire nnc_cmd_t     cmd,
    output nnc_stat_t         st,
    input  wire logic [159:0] in_data,
    input  wire logic         in_op,
    input  wire logic         in_last,
    input  wire logic [31:0]  eq_dist,
    input  wire logic [31:0]  time_step,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [63:0]       out_data,
    output logic [2:0]        out_flags
);

    // Only the first two species are carried by the fields; further species
    // stay zero forever and need no storage.
    localparam int LANES = (SPECIES < 2) ? SPECIES : 2;

    logic [31:0] in_pos [3];
    logic [31:0] in_conc [2];

    logic [31:0] agent_pos_reg [3];
    logic [31:0] agent_conc_reg [LANES];
    logic [31:0] best_conc_reg [LANES];
    logic [31:0] item_conc_reg [LANES];
    logic [63:0] best_reg;
    logic        found_reg;
    logic        item_last_reg;
    logic [31:0] dx_reg, dy_reg, dz_reg;

    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_out;
    logic [63:0] sq_sum;

    logic [63:0] src_reg;
    logic [34:0] rem_reg;
    logic [31:0] root_reg;
    logic [34:0] rem_sh, trial, rem_next;
    logic        sq_ge;

    logic [32:0] divrem_reg;
    logic [16:0] frac_reg;
    logic [32:0] div_sub;
    logic        div_ge;

    logic [31:0] diff_reg;
    logic        gt_reg;
    logic [48:0] upd_sum;
    logic [31:0] upd_sat;

    logic [LANES-1:0] raised_reg;
    logic        out_valid_reg;
    logic [31:0] out_c0_reg, out_c1_reg;
    logic [2:0]  out_flags_reg;
    logic [31:0] conc_second_w;
    logic        raised_second_w;

    assign in_pos[0]  = in_data[31:0];
    assign in_pos[1]  = in_data[63:32];
    assign in_pos[2]  = in_data[95:64];
    assign in_conc[0] = in_data[127:96];
    assign in_conc[1] = in_data[159:128];

    // Shared multiplier operand selection.
    always_comb
    begin
        case (cmd.mul_sel)
            MS_DX:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            MS_DY:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
            MS_DZ:
            begin
                mul_a = dz_reg;
                mul_b = dz_reg;
            end
            MS_DD:
            begin
                mul_a = eq_dist;
                mul_b = eq_dist;
            end
            MS_FRAC:
            begin
                mul_a = {15'd0, frac_reg};
                mul_b = diff_reg;
            end
            MS_DT:
            begin
                mul_a = prod_reg[47:16];
                mul_b = time_step;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_out = {32'd0, mul_a} * {32'd0, mul_b};
    assign sq_sum  = sat_add64(acc_reg, prod_reg);

    // Square root: two bits of the radicand per step.
    assign rem_sh   = {rem_reg[32:0], src_reg[63:62]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign sq_ge    = (rem_sh >= trial);
    assign rem_next = sq_ge ? (rem_sh - trial) : rem_sh;

    // Restoring divide, one quotient bit per step.
    assign div_ge  = (divrem_reg >= {1'b0, eq_dist});
    assign div_sub = div_ge ? (divrem_reg - {1'b0, eq_dist}) : divrem_reg;

    assign upd_sum = {17'd0, agent_conc_reg[cmd.lane]} + {1'b0, prod_reg[63:16]};
    assign upd_sat = (|upd_sum[48:32]) ? 32'hFFFF_FFFF : upd_sum[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                agent_pos_reg[i] <= 32'd0;
            end
            for (int s = 0; s < LANES; s++)
            begin
                agent_conc_reg[s] <= 32'd0;
            end
            best_reg      <= BEST_RESET;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take && (in_op == OP_AGENT))
            begin
                for (int i = 0; i < 3; i++)
                begin
                    agent_pos_reg[i] <= in_pos[i];
                end
                for (int s = 0; s < LANES; s++)
                begin
                    agent_conc_reg[s] <= in_conc[s];
                end
            end
            if (cmd.cmp && (sq_sum < best_reg))
            begin
                best_reg  <= sq_sum;
                found_reg <= 1'b1;
            end
            if (cmd.arm_set)
            begin
                best_reg  <= prod_reg;
                found_reg <= 1'b0;
            end
            if (cmd.ln_upd && gt_reg)
            begin
                agent_conc_reg[cmd.lane] <= upd_sat;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_last_reg <= in_last;
            dx_reg <= abs_diff(agent_pos_reg[0], in_pos[0]);
            dy_reg <= abs_diff(agent_pos_reg[1], in_pos[1]);
            dz_reg <= abs_diff(agent_pos_reg[2], in_pos[2]);
            for (int s = 0; s < LANES; s++)
            begin
                item_conc_reg[s] <= in_conc[s];
            end
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_out;
        end
        if (cmd.acc_load)
        begin
            acc_reg <= prod_reg;
        end
        if (cmd.acc_add)
        begin
            acc_reg <= sq_sum;
        end
        if (cmd.cmp && (sq_sum < best_reg))
        begin
            for (int s = 0; s < LANES; s++)
            begin
                best_conc_reg[s] <= item_conc_reg[s];
            end
        end
        if (cmd.sqrt_init)
        begin
            src_reg  <= best_reg;
            rem_reg  <= 35'd0;
            root_reg <= 32'd0;
        end
        if (cmd.sqrt_step)
        begin
            src_reg  <= {src_reg[61:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= {root_reg[30:0], sq_ge};
        end
        if (cmd.div_init)
        begin
            divrem_reg <= {1'b0, eq_dist - root_reg};
            frac_reg   <= 17'd0;
        end
        if (cmd.div_step)
        begin
            divrem_reg <= {div_sub[31:0], 1'b0};
            frac_reg   <= {frac_reg[15:0], div_ge};
        end
        if (cmd.frac_zero)
        begin
            frac_reg <= 17'd0;
        end
        if (cmd.ln_diff)
        begin
            gt_reg   <= found_reg && (best_conc_reg[cmd.lane] > agent_conc_reg[cmd.lane]);
            diff_reg <= best_conc_reg[cmd.lane] - agent_conc_reg[cmd.lane];
        end
        if (cmd.clr_flags)
        begin
            raised_reg <= '0;
        end
        if (cmd.ln_upd && gt_reg)
        begin
            raised_reg[cmd.lane] <= 1'b1;
        end
        if (cmd.emit)
        begin
            out_c0_reg    <= agent_conc_reg[0];
            out_c1_reg    <= conc_second_w;
            out_flags_reg <= {found_reg, raised_second_w, raised_reg[0]};
        end
    end

    generate
        if (LANES > 1)
        begin : g_two
            assign conc_second_w   = agent_conc_reg[LANES-1];
            assign raised_second_w = raised_reg[LANES-1];
        end
        else
        begin : g_one
            assign conc_second_w   = 32'd0;
            assign raised_second_w = 1'b0;
        end
    endgenerate

    assign st.in_op     = in_op;
    assign st.item_last = item_last_reg;
    assign st.found     = found_reg;
    assign st.d_nonzero = (eq_dist != 32'd0);
    assign st.root_lt_d = (root_reg < eq_dist);
    assign st.out_busy  = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = {out_c1_reg, out_c0_reg};
    assign out_flags = out_flags_reg;

endmodule
`default_nettype wire

@@ design/nnc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nnc_ctrl
// Sequencer that walks the datapath through agent loads, neighbor
// compares and the per-agent result computation.
// ----------------------------------------------------------------------------
module nnc_ctrl
    import nnc_pkg::*;
#(
    parameter int SPECIES = SPECIES_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output nnc_cmd_t       cmd,
    input  wire nnc_stat_t st
);

    localparam int LANES = (SPECIES < 2) ? SPECIES : 2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_AG_ARM,
        ST_AG_SET,
        ST_NB_X,
        ST_NB_Y,
        ST_NB_Z,
        ST_NB_CMP,
        ST_FIN,
        ST_SQ_STEP,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_LN_DIFF,
        ST_LN_MP,
        ST_LN_MD,
        ST_LN_UPD,
        ST_EMIT,
        ST_RE_ARM,
        ST_RE_SET
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             lane_reg;
    logic             take;

    assign in_ready = (state_reg == ST_IDLE);
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            lane_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        state_reg <= (st.in_op == OP_AGENT) ? ST_AG_ARM : ST_NB_X;
                    end
                end
                ST_AG_ARM:  state_reg <= ST_AG_SET;
                ST_AG_SET:  state_reg <= st.item_last ? ST_FIN : ST_IDLE;
                ST_NB_X:    state_reg <= ST_NB_Y;
                ST_NB_Y:    state_reg <= ST_NB_Z;
                ST_NB_Z:    state_reg <= ST_NB_CMP;
                ST_NB_CMP:  state_reg <= st.item_last ? ST_FIN : ST_IDLE;
                ST_FIN:
                begin
                    cnt_reg  <= '0;
                    lane_reg <= 1'b0;
                    state_reg <= (st.found && st.d_nonzero) ? ST_SQ_STEP : ST_LN_DIFF;
                end
                ST_SQ_STEP:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    begin
                        state_reg <= ST_DIV_INIT;
                    end
                end
                ST_DIV_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= st.root_lt_d ? ST_DIV_STEP : ST_LN_DIFF;
                end
                ST_DIV_STEP:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= ST_LN_DIFF;
                    end
                end
                ST_LN_DIFF: state_reg <= ST_LN_MP;
                ST_LN_MP:   state_reg <= ST_LN_MD;
                ST_LN_MD:   state_reg <= ST_LN_UPD;
                ST_LN_UPD:
                begin
                    if (lane_reg == 1'(LANES - 1))
                    begin
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        lane_reg  <= lane_reg + 1'b1;
                        state_reg <= ST_LN_DIFF;
                    end
                end
                ST_EMIT:
                begin
                    if (!st.out_busy)
                    begin
                        state_reg <= ST_RE_ARM;
                    end
                end
                ST_RE_ARM:  state_reg <= ST_RE_SET;
                ST_RE_SET:  state_reg <= ST_IDLE;
                default:    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = MS_DX;
        cmd.take    = take;
        cmd.lane    = lane_reg;
        unique case (state_reg)
            ST_IDLE: ;
            ST_AG_ARM, ST_RE_ARM:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_DD;
            end
            ST_AG_SET, ST_RE_SET: cmd.arm_set = 1'b1;
            ST_NB_X:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_DX;
            end
            ST_NB_Y:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MS_DY;
                cmd.acc_load = 1'b1;
            end
            ST_NB_Z:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_DZ;
                cmd.acc_add = 1'b1;
            end
            ST_NB_CMP: cmd.cmp = 1'b1;
            ST_FIN:
            begin
                cmd.clr_flags = 1'b1;
                cmd.sqrt_init = st.found && st.d_nonzero;
                cmd.frac_zero = !(st.found && st.d_nonzero);
            end
            ST_SQ_STEP: cmd.sqrt_step = 1'b1;
            ST_DIV_INIT:
            begin
                cmd.div_init  = st.root_lt_d;
                cmd.frac_zero = !st.root_lt_d;
            end
            ST_DIV_STEP: cmd.div_step = 1'b1;
            ST_LN_DIFF:  cmd.ln_diff = 1'b1;
            ST_LN_MP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_FRAC;
            end
            ST_LN_MD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_DT;
            end
            ST_LN_UPD: cmd.ln_upd = 1'b1;
            ST_EMIT:   cmd.emit = !st.out_busy;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

@@ design/nearest_neighbor_concentration_pull_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbor_concentration_pull_core
// Finds the nearest neighbor of one agent inside the interaction radius and
// pulls the agent's two species concentrations toward that neighbor's.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake           Contents
// s_axis    in   tvalid/tready       agent or neighbor word, tlast ends agent
// m_axis    out  tvalid/tready       updated concentrations and flags
// apb       in   psel/penable/pready radius (0x0) and time step (0x4)
//
// One word is taken at a time. A neighbor word steps through the X, Y, Z and
// compare states (one shared 32x32 multiplier forms the three squares in
// turn); an agent word through the arm and set states. A word with tlast adds
// a bit-serial square root (32 steps), a restoring divide (17 steps after a
// setup state) and two multiplies per carried species on the same multiplier.
// The root is skipped when no neighbor was kept or the radius is zero, and
// the divide when the root is not below the radius. The output register lets
// the next word be accepted while a result still waits; a new result stalls
// only while the previous one has not been taken. After reset the search is
// armed at once for the reset radius; there is no clearing pass.
//
module nearest_neighbor_concentration_pull_core
    import nnc_pkg::*;
#(
    parameter int SPECIES = SPECIES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Fields from bit 0: pos_x, pos_y, pos_z, conc_first, conc_second.
    input  wire logic [159:0]          s_axis_tdata,
    // Fields from bit 0: opcode.
    input  wire logic                  s_axis_tuser,
    input  wire logic                  s_axis_tlast,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // Fields from bit 0: new_conc_first, new_conc_second.
    output logic [63:0]                m_axis_tdata,
    // Fields from bit 0: raised_first, raised_second, neighbor_found.
    output logic [2:0]                 m_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    nnc_cmd_t    cmd;
    nnc_stat_t   st;
    logic [31:0] eq_dist_reg;
    logic [31:0] time_step_reg;
    logic        cfg_wr;

    // Configuration registers. Writes must arrive only while the core is idle; the core does not enforce this.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eq_dist_reg   <= EQ_DIST_RESET;
            time_step_reg <= TIME_STEP_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                ADDR_EQ_DIST:   eq_dist_reg   <= pwdata;
                ADDR_TIME_STEP: time_step_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            ADDR_EQ_DIST:   prdata = eq_dist_reg;
            ADDR_TIME_STEP: prdata = time_step_reg;
            default:        prdata = 32'd0;
        endcase
    end

    nnc_ctrl #(
        .SPECIES (SPECIES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .st       (st)
    );

    nnc_datapath #(
        .SPECIES (SPECIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_data   (s_axis_tdata),
        .in_op     (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .eq_dist   (eq_dist_reg),
        .time_step (time_step_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_flags (m_axis_tuser)
    );

`ifndef NO_ASSERTIONS
    // A result is only loaded when the output register is free or draining.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !st.out_busy)
        else $error("result loaded over an untaken result");

    // The root is only taken when a neighbor was kept and the radius is set.
    a_sqrt_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sqrt_init |-> (st.found && st.d_nonzero))
        else $error("square root started without a kept neighbor");

    // The shared units never run in the same cycle.
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.mul_en, cmd.sqrt_step, cmd.div_step}))
        else $error("shared units active together");

    // No word is taken while a result computation is under way.
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sqrt_step || cmd.div_step || cmd.ln_upd) |-> !s_axis_tready)
        else $error("input accepted during result computation");
`endif

endmodule
`default_nettype wire
